FILE: hw/rtl/bwr_pkg.sv
// Shared field widths, codes and controller/datapath interface types for the blob reuse planner.
`default_nettype none

package bwr_pkg;

    localparam int ID_W    = 8;
    localparam int SIZE_W  = 32;
    localparam int ALIGN_W = 16;
    localparam int BIDX_W  = 6;
    localparam int STAT_W  = 2;

    // Operation codes carried in the input tuser.
    localparam logic OP_START = 1'b0;
    localparam logic OP_END   = 1'b1;

    // Result status codes.
    localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
    localparam logic [STAT_W-1:0] ST_DUP     = 2'd1;
    localparam logic [STAT_W-1:0] ST_UNKNOWN = 2'd2;
    localparam logic [STAT_W-1:0] ST_FULL    = 2'd3;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic fetch;
        logic commit;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;
    } t_stat;

endpackage

`default_nettype wire

FILE: hw/rtl/bwr_ctrl.sv
// Sequencer that steps each item through accept, memory fetch and commit.
`default_nettype none

module bwr_ctrl (
    input  wire           i_clk,
    input  wire           i_rst_n,
    input  wire           i_s_tvalid,
    output logic          o_s_tready,
    input  bwr_pkg::t_stat i_stat,
    output bwr_pkg::t_cmd  o_cmd
);
    import bwr_pkg::*;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_FETCH = 2'd1;
    localparam logic [1:0] S_EXEC  = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state      = r_state;
        o_cmd        = '0;
        o_s_tready   = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_FETCH;
                end
            end
            S_FETCH: begin
                o_cmd.fetch = 1'b1;
                n_state     = S_EXEC;
            end
            S_EXEC: begin
                // The result can only be committed once the output register has room.
                if (i_stat.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/bwr_dp.sv
// Datapath: object, blob and free stack storage, counters and the output register.
`default_nettype none

module bwr_dp #(
    parameter int MAX_OBJECTS = 256,
    parameter int MAX_BLOBS   = 64
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  bwr_pkg::t_cmd                  i_cmd,
    output bwr_pkg::t_stat                 o_stat,
    input  wire                            i_opcode,
    input  wire  [bwr_pkg::ID_W-1:0]       i_object_id,
    input  wire  [bwr_pkg::SIZE_W-1:0]     i_object_size,
    input  wire  [bwr_pkg::ALIGN_W-1:0]    i_object_alignment,
    input  wire                            i_m_tready,
    output logic                           o_m_tvalid,
    output logic [bwr_pkg::BIDX_W-1:0]     o_blob_index,
    output logic [bwr_pkg::SIZE_W-1:0]     o_blob_size,
    output logic [bwr_pkg::ALIGN_W-1:0]    o_blob_alignment,
    output logic                           o_group_done,
    output logic [bwr_pkg::STAT_W-1:0]     o_status
);
    import bwr_pkg::*;

    // Object ids are 8 bits wide, so at most 256 object entries are reachable.
    localparam int OBJ_DEPTH = (MAX_OBJECTS < (1 << ID_W)) ? MAX_OBJECTS : (1 << ID_W);
    localparam int OBJ_W     = $clog2(OBJ_DEPTH);
    localparam int BLOB_W    = $clog2(MAX_BLOBS);
    localparam int CNT_W     = $clog2(MAX_BLOBS + 1);
    localparam int PEND_W    = $clog2(OBJ_DEPTH + 1);
    localparam int BEXT_W    = (BLOB_W > BIDX_W) ? BLOB_W : BIDX_W;

    // Storage without reset; an entry's contents are used only after it has been written.
    // An object entry holds its finished flag above the bound blob; it is only
    // meaningful while the object's bit in r_active is set.
    logic [BLOB_W:0]    r_ob_mem [OBJ_DEPTH];
    logic [BLOB_W-1:0]  r_fs_mem [MAX_BLOBS];
    logic [SIZE_W-1:0]  r_bs_mem [MAX_BLOBS];
    logic [ALIGN_W-1:0] r_ba_mem [MAX_BLOBS];

    logic               r_op;
    logic [ID_W-1:0]    r_id;
    logic [SIZE_W-1:0]  r_size;
    logic [ALIGN_W-1:0] r_align;
    logic [BLOB_W:0]    r_ob_q;
    logic [BLOB_W-1:0]  r_fs_q;
    logic [BLOB_W-1:0]  r_b;
    logic               r_reuse;
    logic [SIZE_W-1:0]  r_bs_q;
    logic [ALIGN_W-1:0] r_ba_q;

    logic [OBJ_DEPTH-1:0] r_active;
    logic [CNT_W-1:0]     r_free_cnt;
    logic [CNT_W-1:0]     r_blob_cnt;
    logic [PEND_W-1:0]    r_pend_cnt;

    logic [OBJ_DEPTH-1:0] n_active;
    logic [CNT_W-1:0]     n_free_cnt;
    logic [CNT_W-1:0]     n_blob_cnt;
    logic [PEND_W-1:0]    n_pend_cnt;

    logic                 r_out_valid;
    logic [BIDX_W-1:0]    r_out_b;
    logic [SIZE_W-1:0]    r_out_size;
    logic [ALIGN_W-1:0]   r_out_align;
    logic                 r_out_done;
    logic [STAT_W-1:0]    r_out_st;

    // Fetch stage signals.
    logic [OBJ_W-1:0]  in_idx;
    logic [CNT_W-1:0]  fs_dec;
    logic [BLOB_W-1:0] fs_rd_idx;
    logic              reuse;
    logic [BLOB_W-1:0] fs_b;
    logic [BLOB_W-1:0] ob_b;
    logic [BLOB_W-1:0] n_b;

    // Commit stage signals.
    logic [OBJ_W-1:0]   idx;
    logic               id_ok;
    logic               act;
    logic               fin;
    logic [STAT_W-1:0]  res_st;
    logic [SIZE_W-1:0]  res_size;
    logic [ALIGN_W-1:0] res_align;
    logic               res_done;
    logic               res_bind;
    logic [BEXT_W-1:0]  b_ext;
    logic               wr_obj;
    logic               wr_blob;
    logic               wr_stack;
    logic [BLOB_W-1:0]  push_idx;
    logic [PEND_W-1:0]  pend_dec;

    assign in_idx    = i_object_id[OBJ_W-1:0];
    assign fs_dec    = r_free_cnt - CNT_W'(1);
    assign fs_rd_idx = fs_dec[BLOB_W-1:0];
    assign reuse     = (r_free_cnt != '0) && (r_free_cnt <= CNT_W'(MAX_BLOBS));
    assign fs_b      = (32'(r_fs_q) >= 32'(MAX_BLOBS)) ? '0 : r_fs_q;
    assign ob_b      = (32'(r_ob_q[BLOB_W-1:0]) >= 32'(MAX_BLOBS)) ? '0 : r_ob_q[BLOB_W-1:0];
    assign n_b       = (r_op == OP_START) ? (reuse ? fs_b : r_blob_cnt[BLOB_W-1:0]) : ob_b;

    assign idx       = r_id[OBJ_W-1:0];
    assign id_ok     = 32'(r_id) < 32'(MAX_OBJECTS);
    assign act       = r_active[idx];
    assign fin       = r_ob_q[BLOB_W];
    assign push_idx  = r_free_cnt[BLOB_W-1:0];
    assign pend_dec  = (r_pend_cnt != '0) ? (r_pend_cnt - PEND_W'(1)) : r_pend_cnt;
    assign b_ext     = BEXT_W'(r_b);

    always_comb begin
        n_active   = r_active;
        n_free_cnt = r_free_cnt;
        n_blob_cnt = r_blob_cnt;
        n_pend_cnt = r_pend_cnt;
        res_st     = ST_OK;
        res_size   = '0;
        res_align  = '0;
        res_done   = 1'b0;
        res_bind   = 1'b0;
        wr_obj     = 1'b0;
        wr_blob    = 1'b0;
        wr_stack   = 1'b0;
        if (r_op == OP_START) begin
            if (!id_ok) begin
                res_st = ST_FULL;
            end else if (act) begin
                res_st = ST_DUP;
            end else if (!r_reuse && (r_blob_cnt >= CNT_W'(MAX_BLOBS))) begin
                res_st = ST_FULL;
            end else begin
                res_bind = 1'b1;
                wr_obj   = 1'b1;
                if (r_reuse) begin
                    n_free_cnt = r_free_cnt - CNT_W'(1);
                    res_size   = r_bs_q;
                    res_align  = r_ba_q;
                end else begin
                    // A fresh blob starts with zero size and alignment.
                    n_blob_cnt = r_blob_cnt + CNT_W'(1);
                    wr_blob    = 1'b1;
                end
                n_active[idx] = 1'b1;
                n_pend_cnt    = r_pend_cnt + PEND_W'(1);
            end
        end else begin
            if (!id_ok || !act || fin) begin
                res_st = ST_UNKNOWN;
            end else begin
                res_bind  = 1'b1;
                wr_obj    = 1'b1;
                wr_blob   = 1'b1;
                res_size  = (r_size > r_bs_q) ? r_size : r_bs_q;
                res_align = (r_align > r_ba_q) ? r_align : r_ba_q;
                if (r_free_cnt < CNT_W'(MAX_BLOBS)) begin
                    wr_stack   = 1'b1;
                    n_free_cnt = r_free_cnt + CNT_W'(1);
                end
                n_pend_cnt = pend_dec;
                if (pend_dec == '0) begin
                    // Last pending object ended: the whole group is released.
                    res_done   = 1'b1;
                    n_active   = '0;
                    n_free_cnt = '0;
                    n_blob_cnt = '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_op    <= i_opcode;
            r_id    <= i_object_id;
            r_size  <= i_object_size;
            r_align <= i_object_alignment;
            r_ob_q  <= r_ob_mem[in_idx];
            r_fs_q  <= r_fs_mem[fs_rd_idx];
        end
        if (i_cmd.fetch) begin
            r_b     <= n_b;
            r_reuse <= reuse;
            r_bs_q  <= r_bs_mem[n_b];
            r_ba_q  <= r_ba_mem[n_b];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            if (wr_obj) begin
                // A start clears the finished flag, an end sets it.
                r_ob_mem[idx] <= {(r_op == OP_END), r_b};
            end
            if (wr_blob) begin
                r_bs_mem[r_b] <= res_size;
                r_ba_mem[r_b] <= res_align;
            end
            if (wr_stack) begin
                r_fs_mem[push_idx] <= r_b;
            end
            r_out_b     <= res_bind ? b_ext[BIDX_W-1:0] : '0;
            r_out_size  <= res_size;
            r_out_align <= res_align;
            r_out_done  <= res_done;
            r_out_st    <= res_st;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= '0;
            r_free_cnt  <= '0;
            r_blob_cnt  <= '0;
            r_pend_cnt  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.commit) begin
                r_active   <= n_active;
                r_free_cnt <= n_free_cnt;
                r_blob_cnt <= n_blob_cnt;
                r_pend_cnt <= n_pend_cnt;
            end
            if (i_cmd.commit) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_stat.out_free  = !r_out_valid || i_m_tready;
    assign o_m_tvalid       = r_out_valid;
    assign o_blob_index     = r_out_b;
    assign o_blob_size      = r_out_size;
    assign o_blob_alignment = r_out_align;
    assign o_group_done     = r_out_done;
    assign o_status         = r_out_st;

endmodule

`default_nettype wire

FILE: hw/rtl/buffer_lifetime_blob_reuse.sv
// Top level of the buffer lifetime planner that binds objects to reusable blobs.
//
// Usage:
//   The slave channel takes one lifetime operation per item: tuser is the
//   opcode (start or end), tdata carries object id, size and alignment.
//   Every item produces exactly one result item on the master channel:
//   blob index, blob size and alignment in tdata, the status code in tuser,
//   and tlast set when the last pending object of the group ended and the
//   group state was cleared.
//   Each item passes three steps: accept with a fetch of the object binding
//   and free stack top, a fetch of the chosen blob's record, then the commit.
//   The two dependent memory reads set these steps; a new item is not taken
//   until the last one has committed.
//   A result sits in an output register; the next item is accepted while it
//   waits, and that item's commit holds until the receiver takes the first.
//   Reset clears the object flags, counters and output valid;
//   the memories need no clearing pass.
`default_nettype none

module buffer_lifetime_blob_reuse #(
    parameter int MAX_OBJECTS = 256,
    parameter int MAX_BLOBS   = 64
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_s_tvalid,
    output logic        o_s_tready,
    // [7:0] object_id, [39:8] object_size, [55:40] object_alignment
    input  wire  [55:0] i_s_tdata,
    // [0] opcode
    input  wire         i_s_tuser,
    output logic        o_m_tvalid,
    input  wire         i_m_tready,
    // [5:0] blob_index, [37:6] blob_size, [53:38] blob_alignment, [55:54] zero
    output logic [55:0] o_m_tdata,
    // group_done
    output logic        o_m_tlast,
    // [1:0] status
    output logic [1:0]  o_m_tuser
);
    import bwr_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    logic [BIDX_W-1:0]  blob_index;
    logic [SIZE_W-1:0]  blob_size;
    logic [ALIGN_W-1:0] blob_alignment;

    bwr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    bwr_dp #(
        .MAX_OBJECTS (MAX_OBJECTS),
        .MAX_BLOBS   (MAX_BLOBS)
    ) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .o_stat             (stat),
        .i_opcode           (i_s_tuser),
        .i_object_id        (i_s_tdata[7:0]),
        .i_object_size      (i_s_tdata[39:8]),
        .i_object_alignment (i_s_tdata[55:40]),
        .i_m_tready         (i_m_tready),
        .o_m_tvalid         (o_m_tvalid),
        .o_blob_index       (blob_index),
        .o_blob_size        (blob_size),
        .o_blob_alignment   (blob_alignment),
        .o_group_done       (o_m_tlast),
        .o_status           (o_m_tuser)
    );

    assign o_m_tdata = {2'b00, blob_alignment, blob_size, blob_index};

    // A commit must never overwrite a result the receiver has not taken.
    a_commit_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.commit |-> stat.out_free)
        else $error("commit while output register is occupied");

    // The sequencer issues at most one command per cycle.
    a_cmd_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({cmd.accept, cmd.fetch, cmd.commit}))
        else $error("overlapping sequencer commands");

    // After an item is taken, the slave side closes until that item commits.
    a_no_back_to_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("second item accepted during processing");

    // A group completion is always a successful end.
    a_done_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tlast) |-> (o_m_tuser == ST_OK))
        else $error("group done reported with an error status");

endmodule

`default_nettype wire
